@@ rtl/core/rctld_pkg.sv @@
// Shared types, codes and helpers for the RC charge-time level detector.
// Depends on nothing; used by rc_charge_time_level_detector_core.
package rctld_pkg;

  // Field widths fixed by the capture format
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 15;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CrossW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Default capture buffer depth in bytes
  localparam int unsigned CaptureBytesDef = 4096;

  // Full first byte means the line was still charged
  localparam logic [ByteW-1:0] FullByte = 8'hFF;

  // Status codes
  localparam logic [StatW-1:0] StatOk        = 2'd0;
  localparam logic [StatW-1:0] StatShortBuf  = 2'd1;
  localparam logic [StatW-1:0] StatNotDisch  = 2'd2;

  // Crossing codes
  localparam logic [CrossW-1:0] CrossNone = 2'd0;
  localparam logic [CrossW-1:0] CrossRose = 2'd1;
  localparam logic [CrossW-1:0] CrossFell = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLowThr  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHighThr = 2'd1;

  typedef struct packed {
    logic [ByteW-1:0] sample_byte;
    logic             last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [LevelW-1:0] level;
    logic [CrossW-1:0] crossing;
  } out_beat_t;

  // Position of the lowest set bit, zero for an empty byte
  function automatic logic [2:0] lowest_set_bit(input logic [ByteW-1:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

@@ rtl/core/rc_charge_time_level_detector_core.sv @@
// RC charge-time level detector: scans capture bytes, reports the rise
// position and threshold crossings at the last byte. Uses rctld_pkg.
//
// channel | dir | handshake                 | payload
// --------+-----+---------------------------+--------------------------------
// in      | in  | in_valid_i / in_stall_o   | in_beat_i  (sample_byte, last)
// out     | out | out_valid_o / out_stall_i | out_beat_o (status, level, cross)
// cfg     | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle unless stalled; a last byte gives its
// result beat in the next cycle from the output register. The scan state
// and the result register are the only timing stages, one compare chain
// between them. The input stalls only while a result beat sits in the
// output register and the downstream side stalls. Reset clears the scan
// state, the thresholds and the previous level; no clearing pass is needed.
module rc_charge_time_level_detector_core
  import rctld_pkg::*;
#(
  parameter int unsigned CAPTURE_BYTES = CaptureBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_beat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [LevelW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(CAPTURE_BYTES + 1);
  localparam int unsigned IdxW = $clog2(CAPTURE_BYTES);
  localparam logic [CntW-1:0] CntMax  = CntW'(CAPTURE_BYTES);
  localparam logic [CntW-1:0] CntLast = CntW'(CAPTURE_BYTES - 1);

  logic [LevelW-1:0] low_thr_q, high_thr_q, prev_level_q;
  logic [CntW-1:0]   byte_count_q;
  logic              rise_found_q, first_full_q;
  logic [LevelW-1:0] rise_pos_q;
  logic              out_valid_q;
  out_beat_t         out_beat_q;

  logic              in_acc;
  logic              out_free;
  logic [IdxW-1:0]   byte_idx;
  logic [LevelW-1:0] pos_here, pos_eff;
  logic              first_full_eff;
  logic [LevelW-1:0] cfg_low, cfg_high;
  logic [LevelW:0]   thr_sum;
  out_beat_t         result;

  // Accept while the output register can take a beat
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_acc     = in_valid_i && out_free;

  // Clamp the byte index and form byte_index*8 + bit
  assign byte_idx = (byte_count_q >= CntLast) ? IdxW'(CntLast) : IdxW'(byte_count_q);
  assign pos_here = LevelW'({byte_idx, lowest_set_bit(in_beat_i.sample_byte)});
  assign pos_eff  = rise_found_q ? rise_pos_q : pos_here;
  assign first_full_eff = (byte_count_q == '0) ? (in_beat_i.sample_byte == FullByte)
                                               : first_full_q;

  // Build the result beat for a last byte
  always_comb begin
    result          = '0;
    result.status   = StatOk;
    result.crossing = CrossNone;
    if (in_beat_i.sample_byte == '0) begin
      result.status = StatShortBuf;
    end else if (first_full_eff) begin
      result.status = StatNotDisch;
    end else begin
      result.level = pos_eff;
      if (pos_eff >= high_thr_q && prev_level_q < high_thr_q) begin
        result.crossing = CrossRose;
      end else if (pos_eff <= low_thr_q && prev_level_q > low_thr_q) begin
        result.crossing = CrossFell;
      end
    end
  end

  // Threshold values after a write, for the midpoint reload
  assign cfg_low  = (cfg_index_i == CfgLowThr)  ? cfg_data_i : low_thr_q;
  assign cfg_high = (cfg_index_i == CfgHighThr) ? cfg_data_i : high_thr_q;
  assign thr_sum  = {1'b0, cfg_low} + {1'b0, cfg_high};

  // Thresholds and previous level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q    <= '0;
      high_thr_q   <= '0;
      prev_level_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == CfgLowThr || cfg_index_i == CfgHighThr)) begin
      low_thr_q    <= cfg_low;
      high_thr_q   <= cfg_high;
      prev_level_q <= thr_sum[LevelW:1];
    end else if (in_acc && in_beat_i.last_byte && result.status == StatOk) begin
      prev_level_q <= pos_eff;
    end
  end

  // Advance the scan state, drop it at the end of a capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      rise_found_q <= 1'b0;
      rise_pos_q   <= '0;
      first_full_q <= 1'b0;
    end else if (in_acc) begin
      if (in_beat_i.last_byte) begin
        byte_count_q <= '0;
        rise_found_q <= 1'b0;
        rise_pos_q   <= '0;
        first_full_q <= 1'b0;
      end else begin
        if (byte_count_q < CntMax) byte_count_q <= byte_count_q + 1'b1;
        first_full_q <= first_full_eff;
        if (!rise_found_q && in_beat_i.sample_byte != '0) begin
          rise_found_q <= 1'b1;
          rise_pos_q   <= pos_here;
        end
      end
    end
  end

  // Output register: load on a last byte, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_acc && in_beat_i.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_beat_i.last_byte) out_beat_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // A new result beat follows in the next cycle after an accepted last byte
  a_beat_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_beat_i.last_byte) |=> out_valid_q)
    else $error("result beat missing after last byte");

  // The scan restarts after every last byte
  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_beat_i.last_byte) |=> (byte_count_q == '0 && !rise_found_q))
    else $error("scan state not cleared at end of capture");

  // The byte counter saturates
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntMax)
    else $error("byte counter past capture depth");

  // Error results carry no level and no crossing
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.status != StatOk) |->
      (out_beat_q.level == '0 && out_beat_q.crossing == CrossNone))
    else $error("error result carries level or crossing");

endmodule

@@ verif/tb_rc_charge_time_level_detector_core.sv @@
// Self-checking bench for rc_charge_time_level_detector_core: drives capture bytes
// and threshold writes, predicts each status/level/crossing report and compares it.
// Depends on rctld_pkg and the core; no files or plusargs.
`timescale 1ns / 1ps

module tb_rc_charge_time_level_detector_core;
  import rctld_pkg::*;

  localparam int unsigned CapBytes    = CaptureBytesDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseBytes  = 104;
  localparam logic [LevelW-1:0] LevelMax = '1;
  // Index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef logic [ByteW-1:0] byte_q_t[$];

  // Tracks capture state and thresholds, queues the report each last byte causes
  class level_tracker;
    logic [LevelW-1:0] low_thr, high_thr, prev_level, rise_pos;
    int unsigned       byte_count;
    bit                rise_seen, first_full;
    out_beat_t         expected_reports[$];
    int unsigned       errors;

    function new();
      low_thr    = '0;
      high_thr   = '0;
      prev_level = '0;
      errors     = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      byte_count = 0;
      rise_seen  = 1'b0;
      rise_pos   = '0;
      first_full = 1'b0;
    endfunction

    // Apply a threshold write; a real register reloads the previous level
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [LevelW-1:0] data);
      logic [LevelW:0] sum;
      if (idx == CfgLowThr) begin
        low_thr = data;
      end else if (idx == CfgHighThr) begin
        high_thr = data;
      end else begin
        return;
      end
      sum = {1'b0, low_thr} + {1'b0, high_thr};
      prev_level = sum[LevelW:1];
    endfunction

    // Advance the scan by one accepted byte
    function void take_byte(in_beat_t beat);
      logic [ByteW-1:0] b;
      int unsigned      idx;
      int unsigned      bit_pos;
      out_beat_t        rep;
      b = beat.sample_byte;
      if (byte_count == 0) first_full = (b == FullByte);
      idx = (byte_count > CapBytes - 1) ? CapBytes - 1 : byte_count;
      if (!rise_seen && b != '0) begin
        bit_pos = 0;
        while (!b[bit_pos]) bit_pos++;
        rise_pos  = LevelW'(idx * ByteW + bit_pos);
        rise_seen = 1'b1;
      end
      if (byte_count < CapBytes) byte_count++;
      if (!beat.last_byte) return;
      rep.level    = '0;
      rep.crossing = CrossNone;
      if (b == '0) begin
        rep.status = StatShortBuf;
      end else if (first_full) begin
        rep.status = StatNotDisch;
      end else begin
        rep.status = StatOk;
        rep.level  = rise_pos;
        if (rise_pos >= high_thr && prev_level < high_thr) begin
          rep.crossing = CrossRose;
        end else if (rise_pos <= low_thr && prev_level > low_thr) begin
          rep.crossing = CrossFell;
        end
        prev_level = rise_pos;
      end
      expected_reports.push_back(rep);
      clear_capture();
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, got_v);
        errors++;
      end
    endfunction

    // Match one accepted report against the oldest expectation
    function void check_report(out_beat_t got);
      out_beat_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual status %0d level %0d crossing %0d",
                 $time, got.status, got.level, got.crossing);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare("status", want.status, got.status);
      compare("level", want.level, got.level);
      compare("crossing", want.crossing, got.crossing);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_beat_t            in_beat_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_beat_t           out_beat_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [LevelW-1:0]   cfg_data_i  = '0;

  level_tracker tracker;
  bit           idle_on    = 1'b1;
  int unsigned  bytes_sent = 0;
  int unsigned  stall_left = 0;
  int unsigned  cycles     = 0;

  rc_charge_time_level_detector_core #(
    .CAPTURE_BYTES(CapBytes)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o(out_beat_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the report channel in random bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every report beat taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_report(out_beat_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one byte, hold it until taken, then feed it to the tracker
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= '{sample_byte: b, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(in_beat_i);
    bytes_sent++;
  endtask

  task automatic send_capture(input byte_q_t cap);
    for (int i = 0; i < cap.size(); i++) send_byte(cap[i], i == cap.size() - 1);
  endtask

  // Hold input until every report is in, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [LevelW-1:0] lo, input logic [LevelW-1:0] hi);
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(CfgLowThr, lo);
      cfg_write(CfgHighThr, hi);
    end else begin
      cfg_write(CfgHighThr, hi);
      cfg_write(CfgLowThr, lo);
    end
  endtask

  // Zero run followed by one closing byte
  task automatic long_capture(input int unsigned zeros, input logic [ByteW-1:0] tail);
    byte_q_t cap;
    repeat (zeros) cap.push_back('0);
    cap.push_back(tail);
    send_capture(cap);
  endtask

  // Mostly clean rising captures with random content, plus noise and broken ones
  task automatic random_capture();
    byte_q_t     cap;
    int unsigned kind;
    int unsigned zeros;
    int unsigned tail;
    kind  = $urandom_range(0, 9);
    zeros = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    tail  = $urandom_range(0, 5);
    if (kind == 7) begin
      repeat ($urandom_range(1, 12)) cap.push_back(ByteW'($urandom_range(0, 255)));
    end else if (kind == 9) begin
      // line never discharged
      cap.push_back(FullByte);
      repeat (tail) cap.push_back(ByteW'($urandom_range(0, 255)));
      cap.push_back(ByteW'($urandom_range(1, 255)));
    end else begin
      repeat (zeros) cap.push_back('0);
      cap.push_back(($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(1, 255))
                                                 : FullByte << $urandom_range(0, 7));
      repeat (tail) begin
        cap.push_back(($urandom_range(0, 2) == 0) ? ByteW'($urandom_range(1, 255)) : FullByte);
      end
      // buffer ran out before the line settled
      if (kind == 8) cap.push_back('0);
    end
    send_capture(cap);
  endtask

  // Status precedence, both crossings and an ignored register index
  task automatic directed_captures();
    byte_q_t cap;
    cap = '{8'h00};                      send_capture(cap);
    cap = '{8'hFF};                      send_capture(cap);
    cap = '{8'hFF, 8'h00};               send_capture(cap);
    cap = '{8'h80};                      send_capture(cap);
    cap = '{8'h01};                      send_capture(cap);
    cap = '{8'h00, 8'h00, 8'hF0, 8'hFF}; send_capture(cap);
    cap = '{8'h00, 8'h03, 8'h00};        send_capture(cap);
    wait_drained();
    set_thresholds(15'd10, 15'd30);
    cfg_write(CfgSpare, 15'h5555);
    cap = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01}; send_capture(cap);
    cap = '{8'h02};                      send_capture(cap);
    cap = '{8'h55, 8'hAA};               send_capture(cap);
  endtask

  initial begin
    logic [LevelW-1:0] lo, hi;
    int unsigned       target;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_captures();

    // Random phases, each under its own threshold setting
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: begin
          lo = '0;
          hi = LevelMax;
        end
        1: begin
          lo = LevelMax;
          hi = '0;
        end
        2: begin
          lo = LevelW'($urandom_range(0, 120));
          hi = lo;
        end
        default: begin
          lo = LevelW'($urandom_range(0, 60));
          hi = LevelW'($urandom_range(20, 120));
        end
      endcase
      set_thresholds(lo, hi);
      if (p == 3) cfg_write(CfgSpare, LevelW'($urandom_range(0, 32767)));
      idle_on = (p < 6);
      target  = bytes_sent + PhaseBytes;
      while (bytes_sent < target) random_capture();
    end

    // Long zero runs push the rise position up by whole bytes
    wait_drained();
    set_thresholds(15'd500, 15'd900);
    long_capture(120, 8'hF0);
    long_capture(60, 8'h80);
    long_capture(40, 8'h01);
    long_capture(20, 8'h00);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
